FILE: sv/hsl_pkg.sv
`default_nettype none
package hsl_pkg;

    localparam int FRAC_BITS = 16;
    // widest divisor is six times the channel spread: 6 * 255 = 1530
    localparam int DIV_W     = 11;
    localparam int NUM_W     = DIV_W + FRAC_BITS;
    localparam int LANES     = 3;
    localparam int LANE_HUE  = 0;
    localparam int LANE_SAT  = 1;
    localparam int LANE_LIT  = 2;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_rgb;

    typedef struct packed {
        logic [FRAC_BITS-1:0] hue_out;
        logic [FRAC_BITS-1:0] saturation_out;
        logic [FRAC_BITS-1:0] lightness_out;
        logic                 is_gray;
    } t_hsl;

    // one long division in flight: partial remainder, dividend bits still
    // to shift in, quotient so far and the divisor
    typedef struct packed {
        logic [DIV_W-1:0]     rem;
        logic [FRAC_BITS-1:0] low;
        logic [FRAC_BITS-1:0] quo;
        logic [DIV_W-1:0]     div;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lane;
        logic              gray;
    } t_word;

    // x * (2^FRAC_BITS - 1) as a shift and a subtract
    function automatic logic [NUM_W-1:0] scale_full(input logic [DIV_W-1:0] x);
        logic [NUM_W-1:0] sh;
        sh = {x, {FRAC_BITS{1'b0}}};
        return sh - NUM_W'(x);
    endfunction

endpackage
`default_nettype wire

FILE: sv/rgb_to_hsl_converter.sv
`default_nettype none
// RGB to HSL converter. Takes an RGB word (three 8-bit channels) and returns hue,
// saturation and lightness as unsigned 16-bit fractions of full scale 65535,
// truncated, plus a flag for grey pixels (hue and saturation then 0). The
// block accepts a word every cycle unless the output stalls; each word passes
// through a register stage that finds the extremes and forms dividends, then
// through a chain of 16 division cells, each producing one quotient bit of all three fractions.
// A stall at the output freezes the whole chain.
module rgb_to_hsl_converter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire hsl_pkg::t_rgb i_pix,
    output logic               o_valid,
    input  wire logic          i_ready,
    output hsl_pkg::t_hsl      o_hsl
);
    import hsl_pkg::*;

    logic                   en;
    logic  [FRAC_BITS:0]    v;
    t_word [FRAC_BITS:0]    w;

    // move the whole chain when the last cell is empty or being read
    assign en      = !v[FRAC_BITS] || i_ready;
    assign o_ready = en;

    hsl_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pix   (i_pix),
        .o_valid (v[0]),
        .o_word  (w[0])
    );

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_cell
        hsl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_word  (w[g]),
            .o_valid (v[g+1]),
            .o_word  (w[g+1])
        );
    end

    assign o_valid              = v[FRAC_BITS];
    assign o_hsl.hue_out        = w[FRAC_BITS].lane[LANE_HUE].quo;
    assign o_hsl.saturation_out = w[FRAC_BITS].lane[LANE_SAT].quo;
    assign o_hsl.lightness_out  = w[FRAC_BITS].lane[LANE_LIT].quo;
    assign o_hsl.is_gray        = w[FRAC_BITS].gray;

    a_gray_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hsl.is_gray |-> o_hsl.hue_out == '0 && o_hsl.saturation_out == '0)
        else $error("grey word with non-zero hue or saturation");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready out of step with output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule
`default_nettype wire

FILE: sv/hsl_prep.sv
`default_nettype none
module hsl_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire hsl_pkg::t_rgb i_pix,
    output logic               o_valid,
    output hsl_pkg::t_word     o_word
);
    import hsl_pkg::*;

    logic             r_valid;
    t_word            r_word;
    t_word            n_word;
    logic [7:0]       hi, lo, diff;
    logic [8:0]       sum;
    logic [DIV_W-1:0] hue_num, d6, sat_div;
    logic [NUM_W-1:0] n_hue, n_sat, n_lit;

    // find extremes, sector numerator and divisors
    always_comb begin
        hi = i_pix.red_in;
        lo = i_pix.red_in;
        if (i_pix.green_in > hi) hi = i_pix.green_in;
        if (i_pix.blue_in  > hi) hi = i_pix.blue_in;
        if (i_pix.green_in < lo) lo = i_pix.green_in;
        if (i_pix.blue_in  < lo) lo = i_pix.blue_in;
        sum  = {1'b0, hi} + {1'b0, lo};
        diff = hi - lo;
        d6   = DIV_W'(diff) * DIV_W'(6);
        if (hi == i_pix.red_in) begin
            if (i_pix.green_in < i_pix.blue_in)
                hue_num = d6 - DIV_W'(i_pix.blue_in - i_pix.green_in);
            else
                hue_num = DIV_W'(i_pix.green_in - i_pix.blue_in);
        end else if (hi == i_pix.green_in) begin
            hue_num = (DIV_W'(diff) << 1) + DIV_W'(i_pix.blue_in) - DIV_W'(i_pix.red_in);
        end else begin
            hue_num = (DIV_W'(diff) << 2) + DIV_W'(i_pix.red_in) - DIV_W'(i_pix.green_in);
        end
        if (sum <= 9'd255) sat_div = DIV_W'(sum);
        else               sat_div = DIV_W'(10'd510 - {1'b0, sum});

        n_hue = scale_full(hue_num);
        n_sat = scale_full(DIV_W'(diff));
        n_lit = scale_full(DIV_W'(sum));

        n_word = '0;
        n_word.gray = (diff == 8'd0);
        n_word.lane[LANE_LIT].rem = n_lit[NUM_W-1 -: DIV_W];
        n_word.lane[LANE_LIT].low = n_lit[FRAC_BITS-1:0];
        n_word.lane[LANE_LIT].div = DIV_W'(510);
        // achromatic: divide zero by one so hue and saturation come out 0
        if (diff == 8'd0) begin
            n_word.lane[LANE_HUE].div = DIV_W'(1);
            n_word.lane[LANE_SAT].div = DIV_W'(1);
        end else begin
            n_word.lane[LANE_HUE].rem = n_hue[NUM_W-1 -: DIV_W];
            n_word.lane[LANE_HUE].low = n_hue[FRAC_BITS-1:0];
            n_word.lane[LANE_HUE].div = d6;
            n_word.lane[LANE_SAT].rem = n_sat[NUM_W-1 -: DIV_W];
            n_word.lane[LANE_SAT].low = n_sat[FRAC_BITS-1:0];
            n_word.lane[LANE_SAT].div = sat_div;
        end
    end

    // hold on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule
`default_nettype wire

FILE: sv/hsl_div_cell.sv
`default_nettype none
module hsl_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire hsl_pkg::t_word i_word,
    output logic                o_valid,
    output hsl_pkg::t_word      o_word
);
    import hsl_pkg::*;

    logic             r_valid;
    t_word            r_word;
    t_word            n_word;
    logic [DIV_W:0]   sh;

    // one restoring division step in every lane
    always_comb begin
        n_word = i_word;
        sh     = '0;
        for (int k = 0; k < LANES; k++) begin
            sh = {i_word.lane[k].rem, i_word.lane[k].low[FRAC_BITS-1]};
            n_word.lane[k].low = {i_word.lane[k].low[FRAC_BITS-2:0], 1'b0};
            if (sh >= {1'b0, i_word.lane[k].div}) begin
                n_word.lane[k].rem = DIV_W'(sh - {1'b0, i_word.lane[k].div});
                n_word.lane[k].quo = {i_word.lane[k].quo[FRAC_BITS-2:0], 1'b1};
            end else begin
                n_word.lane[k].rem = sh[DIV_W-1:0];
                n_word.lane[k].quo = {i_word.lane[k].quo[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    // advance with the chain, hold on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule
`default_nettype wire

FILE: tb/hsl_checker.sv
`default_nettype none
module hsl_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_o_ready,
    input  wire hsl_pkg::t_rgb i_pix,
    input  wire logic          i_o_valid,
    input  wire logic          i_ready,
    input  wire hsl_pkg::t_hsl i_hsl,
    output int                 o_fail_count,
    output int                 o_pending
);
    import hsl_pkg::*;

    localparam longint FULL = (64'd1 << FRAC_BITS) - 1;

    t_hsl hsl_queue[$];

    // compute the HSL word that a pixel must yield
    function automatic t_hsl hsl_of(input t_rgb p);
        longint rc, gc, bc, hi, lo, sum, diff, num;
        t_hsl r;
        rc = p.red_in;
        gc = p.green_in;
        bc = p.blue_in;
        hi = rc;
        lo = rc;
        if (gc > hi) hi = gc;
        if (bc > hi) hi = bc;
        if (gc < lo) lo = gc;
        if (bc < lo) lo = bc;
        sum  = hi + lo;
        diff = hi - lo;
        r = '0;
        r.lightness_out = FRAC_BITS'((sum * FULL) / 510);
        r.is_gray = (diff == 0);
        if (diff != 0) begin
            if (sum <= 255) r.saturation_out = FRAC_BITS'((diff * FULL) / sum);
            else r.saturation_out = FRAC_BITS'((diff * FULL) / (510 - sum));
            // red first, then green, then blue on ties
            if (hi == rc) begin
                if (gc < bc) num = 6 * diff - (bc - gc);
                else num = gc - bc;
            end else if (hi == gc) begin
                num = 2 * diff + bc - rc;
            end else begin
                num = 4 * diff + rc - gc;
            end
            r.hue_out = FRAC_BITS'((num * FULL) / (6 * diff));
        end
        return r;
    endfunction

    // predict on accepted pixels, compare accepted results
    always @(posedge i_clk) begin
        t_hsl want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && i_o_ready) hsl_queue.push_back(hsl_of(i_pix));
            if (i_o_valid && i_ready) begin
                if (hsl_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected word %h", i_hsl);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = hsl_queue.pop_front();
                    if (want !== i_hsl) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp h=%h s=%h l=%h g=%b got h=%h s=%h l=%h g=%b",
                                want.hue_out, want.saturation_out, want.lightness_out,
                                want.is_gray, i_hsl.hue_out, i_hsl.saturation_out,
                                i_hsl.lightness_out, i_hsl.is_gray);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= hsl_queue.size();
    end
endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
    import hsl_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_ready = 0;
    t_rgb i_pix = '0;
    logic o_ready, o_valid;
    t_hsl o_hsl;
    int   fail_count, pending;
    int   cycle_count = 0;
    logic calm = 0;

    always #4 i_clk = ~i_clk;

    rgb_to_hsl_converter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_pix(i_pix), .o_valid(o_valid), .i_ready(i_ready), .o_hsl(o_hsl)
    );

    hsl_checker i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_o_ready(o_ready),
        .i_pix(i_pix), .i_o_valid(o_valid), .i_ready(i_ready), .i_hsl(o_hsl),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // stall the result side at random, except during the calm stretch
    always @(posedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end

    // end the run at a generous limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("status: fail");
            $finish;
        end
    end

    // offer one pixel word and hold it until accepted
    task automatic send_pixel(input t_rgb p);
        while (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic t_rgb mk(input int r, input int g, input int b);
        t_rgb p;
        p.red_in   = r[7:0];
        p.green_in = g[7:0];
        p.blue_in  = b[7:0];
        return p;
    endfunction

    initial begin
        t_rgb p;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes, greys, hue ties, wrap and each sector
        send_pixel(mk(0, 0, 0));
        send_pixel(mk(255, 255, 255));
        send_pixel(mk(128, 128, 128));
        send_pixel(mk(127, 127, 127));
        send_pixel(mk(255, 0, 0));
        send_pixel(mk(0, 255, 0));
        send_pixel(mk(0, 0, 255));
        send_pixel(mk(255, 255, 0));
        send_pixel(mk(0, 255, 255));
        send_pixel(mk(255, 0, 255));
        send_pixel(mk(255, 0, 1));
        send_pixel(mk(255, 254, 0));
        send_pixel(mk(200, 10, 100));
        send_pixel(mk(1, 0, 0));
        send_pixel(mk(255, 254, 254));
        send_pixel(mk(128, 127, 127));
        send_pixel(mk(127, 128, 0));
        send_pixel(mk(10, 20, 255));
        send_pixel(mk(170, 85, 0));
        send_pixel(mk(254, 1, 255));
        // random pixels; some with shared channels to hit ties and greys
        for (k = 0; k < 1750; k++) begin
            calm = (k >= 600 && k < 900);
            p = t_rgb'($urandom);
            case ($urandom_range(7))
                0: p.green_in = p.red_in;
                1: p.blue_in = p.green_in;
                2: begin
                    p.green_in = p.red_in;
                    p.blue_in  = p.red_in;
                end
                3: p.red_in = 8'($urandom_range(1) * 255);
                default: ;
            endcase
            send_pixel(p);
        end
        calm = 0;
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
